### rtl/core/hric_pkg.sv
package hric_pkg;

   localparam int unsigned TIMER_BITS_DEFAULT = 16;
   localparam int unsigned CFG_BITS           = 16;
   localparam int unsigned CSR_DATA_BITS      = 32;
   localparam int unsigned CSR_ADDR_BITS      = 4;
   localparam int unsigned STATUS_BITS        = 6;
   localparam int unsigned NUM_PULSES         = 3;

   localparam int unsigned PULSE_SPEED1 = 0;
   localparam int unsigned PULSE_SPEED2 = 1;
   localparam int unsigned PULSE_RESET  = 2;

   localparam logic [CFG_BITS-1:0] LINK_TIMEOUT_RESET   = 16'd500;
   localparam logic [CFG_BITS-1:0] PULSE_LENGTH_RESET   = 16'd200;
   localparam logic [CFG_BITS-1:0] STATUS_INTERVAL_RESET = 16'd200;
   localparam logic [CFG_BITS-1:0] BLINK_HALF_RESET     = 16'd250;

   typedef enum logic [1:0] {
      REG_LINK_TIMEOUT    = 2'd0,
      REG_PULSE_LENGTH    = 2'd1,
      REG_STATUS_INTERVAL = 2'd2,
      REG_BLINK_HALF      = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_UP     = 3'd1,
      CMD_DOWN   = 3'd2,
      CMD_SPEED1 = 3'd3,
      CMD_SPEED2 = 3'd4,
      CMD_RST    = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] link_timeout_ms;
      logic [CFG_BITS-1:0] pulse_length_ms;
      logic [CFG_BITS-1:0] status_interval_ms;
      logic [CFG_BITS-1:0] blink_half_period_ms;
   } cfg_type;

   typedef struct packed {
      logic       packet_valid;
      logic [2:0] packet_command;
      logic       packet_hold;
      logic       packet_emergency;
      logic       packet_end_travel;
      logic       button_up;
      logic       button_down;
      logic       motor_feedback;
      logic       emergency_feedback;
      logic       speed1_feedback;
      logic       speed2_feedback;
      logic       brake_switch;
   } item_type;

   typedef struct packed {
      logic                   drive_up;
      logic                   drive_down;
      logic                   speed1_pulse;
      logic                   speed2_pulse;
      logic                   reset_pulse;
      logic                   emergency_out;
      logic                   end_travel_out;
      logic                   status_send;
      logic [STATUS_BITS-1:0] status_word;
      logic                   link_led;
   } result_type;

endpackage

### rtl/core/hric_core.sv
module hric_core #(
   parameter int unsigned TIMER_BITS = hric_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  hric_pkg::cfg_type    cfg,
   input  hric_pkg::item_type   item,
   output hric_pkg::result_type result
);
   import hric_pkg::*;

   localparam int unsigned CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

   logic [TIMER_BITS-1:0] link_idle_count_ff, link_idle_count_in;
   logic                  hold_active_ff, hold_active_in;
   dir_type               hold_direction_ff, hold_direction_in;
   logic                  remote_emergency_ff, remote_emergency_in;
   logic                  remote_end_travel_ff, remote_end_travel_in;
   logic [NUM_PULSES-1:0] pulse_active_ff, pulse_active_in;
   logic [TIMER_BITS-1:0] pulse_elapsed_ff [NUM_PULSES];
   logic [TIMER_BITS-1:0] pulse_elapsed_in [NUM_PULSES];
   logic [TIMER_BITS-1:0] status_elapsed_ff, status_elapsed_in;
   logic [STATUS_BITS-1:0] last_status_ff, last_status_in;
   logic [TIMER_BITS-1:0] blink_elapsed_ff, blink_elapsed_in;
   logic                  blink_phase_ff, blink_phase_in;

   logic                   lost;
   logic                   permitted;
   logic [STATUS_BITS-1:0] word;
   logic                   send;
   logic                   led;
   logic                   up;
   logic                   down;
   logic [TIMER_BITS-1:0]  blink_base;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
      return (v == {TIMER_BITS{1'b1}}) ? v : v + TIMER_BITS'(1);
   endfunction

   function automatic logic reached(input logic [TIMER_BITS-1:0] count,
                                    input logic [CFG_BITS-1:0] limit);
      return CMP_BITS'(count) >= CMP_BITS'(limit);
   endfunction

   always_comb begin
      // link watchdog
      if (item.packet_valid || item.button_up || item.button_down) begin
         link_idle_count_in = '0;
      end else begin
         link_idle_count_in = sat_inc(link_idle_count_ff);
      end
      lost = reached(link_idle_count_in, cfg.link_timeout_ms);

      hold_active_in       = hold_active_ff;
      hold_direction_in    = hold_direction_ff;
      remote_emergency_in  = remote_emergency_ff;
      remote_end_travel_in = remote_end_travel_ff;
      if (lost) begin
         hold_active_in       = 1'b0;
         hold_direction_in    = DIR_NONE;
         remote_emergency_in  = 1'b0;
         remote_end_travel_in = 1'b0;
      end

      pulse_active_in = pulse_active_ff;
      for (int k = 0; k < NUM_PULSES; k++) begin
         pulse_elapsed_in[k] = pulse_active_ff[k] ? sat_inc(pulse_elapsed_ff[k])
                                                  : pulse_elapsed_ff[k];
      end

      // remote packet
      if (item.packet_valid) begin
         remote_emergency_in  = item.packet_emergency;
         remote_end_travel_in = item.packet_end_travel;
         hold_active_in       = 1'b0;
         hold_direction_in    = DIR_NONE;
         case (cmd_type'(item.packet_command))
            CMD_UP: begin
               if (item.packet_hold) begin
                  hold_active_in    = 1'b1;
                  hold_direction_in = DIR_UP;
               end
            end
            CMD_DOWN: begin
               if (item.packet_hold) begin
                  hold_active_in    = 1'b1;
                  hold_direction_in = DIR_DOWN;
               end
            end
            CMD_SPEED1: begin
               pulse_active_in[PULSE_SPEED2] = 1'b0;
               pulse_active_in[PULSE_SPEED1] = 1'b1;
               pulse_elapsed_in[PULSE_SPEED1] = '0;
            end
            CMD_SPEED2: begin
               pulse_active_in[PULSE_SPEED1] = 1'b0;
               pulse_active_in[PULSE_SPEED2] = 1'b1;
               pulse_elapsed_in[PULSE_SPEED2] = '0;
            end
            CMD_RST: begin
               pulse_active_in[PULSE_RESET] = 1'b1;
               pulse_elapsed_in[PULSE_RESET] = '0;
            end
            default: ;
         endcase
      end

      // motion gating; local buttons only when no remote hold
      permitted = !lost && !remote_emergency_in && !item.emergency_feedback &&
                  !item.brake_switch && item.motor_feedback;
      up   = 1'b0;
      down = 1'b0;
      if (permitted && hold_active_in && hold_direction_in == DIR_UP) begin
         up = 1'b1;
      end else if (permitted && hold_active_in && hold_direction_in == DIR_DOWN) begin
         down = 1'b1;
      end else if (!hold_active_in && !lost) begin
         if (item.button_up) begin
            up = 1'b1;
         end else if (item.button_down) begin
            down = 1'b1;
         end
      end

      for (int k = 0; k < NUM_PULSES; k++) begin
         if (pulse_active_in[k] && reached(pulse_elapsed_in[k], cfg.pulse_length_ms)) begin
            pulse_active_in[k] = 1'b0;
         end
      end

      // status word
      word = {item.brake_switch, item.speed2_feedback, item.speed1_feedback,
              item.emergency_feedback, item.motor_feedback, !lost};
      status_elapsed_in = sat_inc(status_elapsed_ff);
      send = reached(status_elapsed_in, cfg.status_interval_ms) || (word != last_status_ff);
      last_status_in = last_status_ff;
      if (send) begin
         status_elapsed_in = '0;
         last_status_in    = word;
      end

      // link LED
      blink_base = blink_elapsed_ff;
      if (!lost) begin
         blink_elapsed_in = '0;
         blink_phase_in   = 1'b0;
         led              = 1'b1;
      end else begin
         blink_phase_in = blink_phase_ff;
         if (reached(blink_elapsed_ff, cfg.blink_half_period_ms)) begin
            blink_phase_in = !blink_phase_ff;
            blink_base     = '0;
         end
         led              = !blink_phase_in;
         blink_elapsed_in = sat_inc(blink_base);
      end

      result.drive_up       = up;
      result.drive_down     = down;
      result.speed1_pulse   = pulse_active_in[PULSE_SPEED1];
      result.speed2_pulse   = pulse_active_in[PULSE_SPEED2];
      result.reset_pulse    = pulse_active_in[PULSE_RESET];
      result.emergency_out  = lost || remote_emergency_in;
      result.end_travel_out = remote_end_travel_in;
      result.status_send    = send;
      result.status_word    = word;
      result.link_led       = led;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_idle_count_ff   <= '0;
         hold_active_ff       <= 1'b0;
         hold_direction_ff    <= DIR_NONE;
         remote_emergency_ff  <= 1'b0;
         remote_end_travel_ff <= 1'b0;
         pulse_active_ff      <= '0;
         for (int k = 0; k < NUM_PULSES; k++) begin
            pulse_elapsed_ff[k] <= '0;
         end
         status_elapsed_ff    <= '0;
         last_status_ff       <= '0;
         blink_elapsed_ff     <= '0;
         blink_phase_ff       <= 1'b0;
      end else if (step) begin
         link_idle_count_ff   <= link_idle_count_in;
         hold_active_ff       <= hold_active_in;
         hold_direction_ff    <= hold_direction_in;
         remote_emergency_ff  <= remote_emergency_in;
         remote_end_travel_ff <= remote_end_travel_in;
         pulse_active_ff      <= pulse_active_in;
         for (int k = 0; k < NUM_PULSES; k++) begin
            pulse_elapsed_ff[k] <= pulse_elapsed_in[k];
         end
         status_elapsed_ff    <= status_elapsed_in;
         last_status_ff       <= last_status_in;
         blink_elapsed_ff     <= blink_elapsed_in;
         blink_phase_ff       <= blink_phase_in;
      end
   end

   a_hold_has_direction: assert property (@(posedge clock) disable iff (reset)
      hold_active_ff |-> (hold_direction_ff == DIR_UP || hold_direction_ff == DIR_DOWN))
      else $error("hold latched without a direction");

   a_speed_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(pulse_active_ff[PULSE_SPEED1] && pulse_active_ff[PULSE_SPEED2]))
      else $error("speed1 and speed2 pulses both running");

   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      step |-> !(result.drive_up && result.drive_down))
      else $error("up and down driven together");

endmodule

### rtl/core/hoist_remote_interlock_controller.sv
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------------
// req      | req_valid/req_stall  | one millisecond tick: packet, buttons, feedbacks
// rsp      | rsp_valid/rsp_stall  | drive, pulse, emergency, status word, LED
// csr      | APB, pready tied high| four 16-bit timing registers at 4*i
//
// One tick is accepted per clock while req_stall is low; its result is registered in the output buffer.
// Results leave through the output register; a two-beat output buffer
// keeps ticks flowing while a result waits, and req_stall rises only when
// both of its entries are full.
// Synchronous reset clears all timers, latches and buffer valids; the
// registers return to 500/200/200/250 ms.
module hoist_remote_interlock_controller #(
   parameter int unsigned TIMER_BITS = hric_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_packet_valid,
   input  logic [2:0]                         req_packet_command,
   input  logic                               req_packet_hold,
   input  logic                               req_packet_emergency,
   input  logic                               req_packet_end_travel,
   input  logic                               req_button_up,
   input  logic                               req_button_down,
   input  logic                               req_motor_feedback,
   input  logic                               req_emergency_feedback,
   input  logic                               req_speed1_feedback,
   input  logic                               req_speed2_feedback,
   input  logic                               req_brake_switch,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_drive_up,
   output logic                               rsp_drive_down,
   output logic                               rsp_speed1_pulse,
   output logic                               rsp_speed2_pulse,
   output logic                               rsp_reset_pulse,
   output logic                               rsp_emergency_out,
   output logic                               rsp_end_travel_out,
   output logic                               rsp_status_send,
   output logic [hric_pkg::STATUS_BITS-1:0]   rsp_status_word,
   output logic                               rsp_link_led,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [hric_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [hric_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [hric_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);
   import hric_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_index;
   logic          csr_write;

   item_type      item;
   result_type    result;
   logic          accept;
   logic          take;

   logic          main_valid_ff, main_valid_in;
   result_type    main_ff, main_in;
   logic          skid_valid_ff, skid_valid_in;
   result_type    skid_ff, skid_in;

   // configuration registers
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.link_timeout_ms      <= LINK_TIMEOUT_RESET;
         cfg_ff.pulse_length_ms      <= PULSE_LENGTH_RESET;
         cfg_ff.status_interval_ms   <= STATUS_INTERVAL_RESET;
         cfg_ff.blink_half_period_ms <= BLINK_HALF_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_LINK_TIMEOUT:    cfg_ff.link_timeout_ms      <= pwdata[CFG_BITS-1:0];
            REG_PULSE_LENGTH:    cfg_ff.pulse_length_ms      <= pwdata[CFG_BITS-1:0];
            REG_STATUS_INTERVAL: cfg_ff.status_interval_ms   <= pwdata[CFG_BITS-1:0];
            REG_BLINK_HALF:      cfg_ff.blink_half_period_ms <= pwdata[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_LINK_TIMEOUT:    prdata = CSR_DATA_BITS'(cfg_ff.link_timeout_ms);
         REG_PULSE_LENGTH:    prdata = CSR_DATA_BITS'(cfg_ff.pulse_length_ms);
         REG_STATUS_INTERVAL: prdata = CSR_DATA_BITS'(cfg_ff.status_interval_ms);
         REG_BLINK_HALF:      prdata = CSR_DATA_BITS'(cfg_ff.blink_half_period_ms);
         default:             prdata = '0;
      endcase
   end

   // tick processing
   assign item.packet_valid       = req_packet_valid;
   assign item.packet_command     = req_packet_command;
   assign item.packet_hold        = req_packet_hold;
   assign item.packet_emergency   = req_packet_emergency;
   assign item.packet_end_travel  = req_packet_end_travel;
   assign item.button_up          = req_button_up;
   assign item.button_down        = req_button_down;
   assign item.motor_feedback     = req_motor_feedback;
   assign item.emergency_feedback = req_emergency_feedback;
   assign item.speed1_feedback    = req_speed1_feedback;
   assign item.speed2_feedback    = req_speed2_feedback;
   assign item.brake_switch       = req_brake_switch;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = main_valid_ff;
   assign take      = main_valid_ff && !rsp_stall;

   hric_core #(
      .TIMER_BITS(TIMER_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .cfg    (cfg_ff),
      .item   (item),
      .result (result)
   );

   // two-entry output buffer; skid entry fills only while the main beat is held
   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (take || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = accept;
            main_in       = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_drive_up       = main_ff.drive_up;
   assign rsp_drive_down     = main_ff.drive_down;
   assign rsp_speed1_pulse   = main_ff.speed1_pulse;
   assign rsp_speed2_pulse   = main_ff.speed2_pulse;
   assign rsp_reset_pulse    = main_ff.reset_pulse;
   assign rsp_emergency_out  = main_ff.emergency_out;
   assign rsp_end_travel_out = main_ff.end_travel_out;
   assign rsp_status_send    = main_ff.status_send;
   assign rsp_status_word    = main_ff.status_word;
   assign rsp_link_led       = main_ff.link_led;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry full while main entry empty");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(main_valid_ff && rsp_stall))
      else $error("skid entry filled without a held result");

   a_accept_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (accept && !main_valid_ff) |=> main_valid_ff)
      else $error("accepted tick did not reach the output register");

endmodule

### test/hric_checker.sv
module hric_checker (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic                               req_packet_valid,
   input  logic [2:0]                         req_packet_command,
   input  logic                               req_packet_hold,
   input  logic                               req_packet_emergency,
   input  logic                               req_packet_end_travel,
   input  logic                               req_button_up,
   input  logic                               req_button_down,
   input  logic                               req_motor_feedback,
   input  logic                               req_emergency_feedback,
   input  logic                               req_speed1_feedback,
   input  logic                               req_speed2_feedback,
   input  logic                               req_brake_switch,

   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_drive_up,
   input  logic                               rsp_drive_down,
   input  logic                               rsp_speed1_pulse,
   input  logic                               rsp_speed2_pulse,
   input  logic                               rsp_reset_pulse,
   input  logic                               rsp_emergency_out,
   input  logic                               rsp_end_travel_out,
   input  logic                               rsp_status_send,
   input  logic [hric_pkg::STATUS_BITS-1:0]   rsp_status_word,
   input  logic                               rsp_link_led,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [hric_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [hric_pkg::CSR_DATA_BITS-1:0] pwdata,
   input  logic [hric_pkg::CSR_DATA_BITS-1:0] prdata,
   input  logic                               pready,

   output int                                 failures,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import hric_pkg::*;

   localparam int unsigned TB = TIMER_BITS_DEFAULT;
   localparam logic [TB-1:0] TICK_MAX = '1;

   cfg_type cfg;

   logic [TB-1:0]   idle_ticks;
   logic            hold_on;
   dir_type         hold_dir;
   logic            rem_emg;
   logic            rem_end;
   logic            pulse_on  [NUM_PULSES];
   logic [TB-1:0]   pulse_age [NUM_PULSES];
   logic [TB-1:0]   beat_age;
   logic [STATUS_BITS-1:0] sent_word;
   logic [TB-1:0]   blink_age;
   logic            blink_dark;

   result_type due_results[$];
   int errs;

   assign failures = errs;

   initial errs = 0;

   function automatic logic [TB-1:0] sat_tick(input logic [TB-1:0] v);
      return (v == TICK_MAX) ? v : v + TB'(1);
   endfunction

   function automatic logic [CFG_BITS-1:0] cfg_value(input reg_index_type idx);
      case (idx)
         REG_LINK_TIMEOUT:    return cfg.link_timeout_ms;
         REG_PULSE_LENGTH:    return cfg.pulse_length_ms;
         REG_STATUS_INTERVAL: return cfg.status_interval_ms;
         default:             return cfg.blink_half_period_ms;
      endcase
   endfunction

   task automatic clear_model();
      cfg.link_timeout_ms      = LINK_TIMEOUT_RESET;
      cfg.pulse_length_ms      = PULSE_LENGTH_RESET;
      cfg.status_interval_ms   = STATUS_INTERVAL_RESET;
      cfg.blink_half_period_ms = BLINK_HALF_RESET;
      idle_ticks = '0;
      hold_on    = 1'b0;
      hold_dir   = DIR_NONE;
      rem_emg    = 1'b0;
      rem_end    = 1'b0;
      for (int k = 0; k < NUM_PULSES; k++) begin
         pulse_on[k]  = 1'b0;
         pulse_age[k] = '0;
      end
      beat_age   = '0;
      sent_word  = '0;
      blink_age  = '0;
      blink_dark = 1'b0;
   endtask

   // one millisecond tick of the interlock
   function automatic result_type advance_tick(input item_type it);
      result_type r;
      logic lost, permitted;
      logic [STATUS_BITS-1:0] word;
      r = '0;

      if (it.packet_valid || it.button_up || it.button_down) idle_ticks = '0;
      else idle_ticks = sat_tick(idle_ticks);
      lost = (idle_ticks >= cfg.link_timeout_ms);
      if (lost) begin
         hold_on  = 1'b0;
         hold_dir = DIR_NONE;
         rem_emg  = 1'b0;
         rem_end  = 1'b0;
      end

      for (int k = 0; k < NUM_PULSES; k++)
         if (pulse_on[k]) pulse_age[k] = sat_tick(pulse_age[k]);

      if (it.packet_valid) begin
         rem_emg  = it.packet_emergency;
         rem_end  = it.packet_end_travel;
         hold_on  = it.packet_hold &&
                    (it.packet_command == CMD_UP || it.packet_command == CMD_DOWN);
         hold_dir = hold_on ? dir_type'(it.packet_command[1:0]) : DIR_NONE;
         case (it.packet_command)
            CMD_SPEED1: begin
               pulse_on[PULSE_SPEED2]  = 1'b0;
               pulse_on[PULSE_SPEED1]  = 1'b1;
               pulse_age[PULSE_SPEED1] = '0;
            end
            CMD_SPEED2: begin
               pulse_on[PULSE_SPEED1]  = 1'b0;
               pulse_on[PULSE_SPEED2]  = 1'b1;
               pulse_age[PULSE_SPEED2] = '0;
            end
            CMD_RST: begin
               pulse_on[PULSE_RESET]  = 1'b1;
               pulse_age[PULSE_RESET] = '0;
            end
            default: ;
         endcase
      end

      permitted = !lost && !rem_emg && !it.emergency_feedback && !it.brake_switch &&
                  it.motor_feedback;
      if (permitted && hold_on && hold_dir == DIR_UP) begin
         r.drive_up = 1'b1;
      end else if (permitted && hold_on && hold_dir == DIR_DOWN) begin
         r.drive_down = 1'b1;
      end else if (!hold_on && !lost) begin
         // local test buttons, up wins
         if (it.button_up) r.drive_up = 1'b1;
         else if (it.button_down) r.drive_down = 1'b1;
      end

      for (int k = 0; k < NUM_PULSES; k++)
         if (pulse_on[k] && pulse_age[k] >= cfg.pulse_length_ms) pulse_on[k] = 1'b0;

      word = {it.brake_switch, it.speed2_feedback, it.speed1_feedback,
              it.emergency_feedback, it.motor_feedback, !lost};
      beat_age = sat_tick(beat_age);
      r.status_send = (beat_age >= cfg.status_interval_ms) || (word != sent_word);
      if (r.status_send) begin
         beat_age  = '0;
         sent_word = word;
      end

      if (!lost) begin
         blink_age  = '0;
         blink_dark = 1'b0;
         r.link_led = 1'b1;
      end else begin
         if (blink_age >= cfg.blink_half_period_ms) begin
            blink_dark = !blink_dark;
            blink_age  = '0;
         end
         r.link_led = !blink_dark;
         blink_age  = sat_tick(blink_age);
      end

      r.speed1_pulse   = pulse_on[PULSE_SPEED1];
      r.speed2_pulse   = pulse_on[PULSE_SPEED2];
      r.reset_pulse    = pulse_on[PULSE_RESET];
      r.emergency_out  = lost || rem_emg;
      r.end_travel_out = rem_end;
      r.status_word    = word;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      item_type   it;
      result_type want, got;
      if (reset) begin
         clear_model();
         due_results.delete();
         pending <= 0;
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (reg_index_type'(paddr[3:2]))
                  REG_LINK_TIMEOUT:    cfg.link_timeout_ms      = pwdata[CFG_BITS-1:0];
                  REG_PULSE_LENGTH:    cfg.pulse_length_ms      = pwdata[CFG_BITS-1:0];
                  REG_STATUS_INTERVAL: cfg.status_interval_ms   = pwdata[CFG_BITS-1:0];
                  default:             cfg.blink_half_period_ms = pwdata[CFG_BITS-1:0];
               endcase
            end else begin
               compare_field("prdata", 32'(cfg_value(reg_index_type'(paddr[3:2]))), prdata);
            end
         end

         // pop before push: a beat's result never leaves on its own edge
         if (rsp_valid && !rsp_stall) begin
            got.drive_up       = rsp_drive_up;
            got.drive_down     = rsp_drive_down;
            got.speed1_pulse   = rsp_speed1_pulse;
            got.speed2_pulse   = rsp_speed2_pulse;
            got.reset_pulse    = rsp_reset_pulse;
            got.emergency_out  = rsp_emergency_out;
            got.end_travel_out = rsp_end_travel_out;
            got.status_send    = rsp_status_send;
            got.status_word    = rsp_status_word;
            got.link_led       = rsp_link_led;
            if (due_results.size() == 0) begin
               $error("result beat with nothing outstanding");
               errs++;
            end else begin
               want = due_results.pop_front();
               compare_field("drive_up", 32'(want.drive_up), 32'(got.drive_up));
               compare_field("drive_down", 32'(want.drive_down), 32'(got.drive_down));
               compare_field("speed1_pulse", 32'(want.speed1_pulse), 32'(got.speed1_pulse));
               compare_field("speed2_pulse", 32'(want.speed2_pulse), 32'(got.speed2_pulse));
               compare_field("reset_pulse", 32'(want.reset_pulse), 32'(got.reset_pulse));
               compare_field("emergency_out", 32'(want.emergency_out),
                             32'(got.emergency_out));
               compare_field("end_travel_out", 32'(want.end_travel_out),
                             32'(got.end_travel_out));
               compare_field("status_send", 32'(want.status_send), 32'(got.status_send));
               compare_field("status_word", 32'(want.status_word), 32'(got.status_word));
               compare_field("link_led", 32'(want.link_led), 32'(got.link_led));
            end
         end

         if (req_valid && !req_stall) begin
            it.packet_valid       = req_packet_valid;
            it.packet_command     = req_packet_command;
            it.packet_hold        = req_packet_hold;
            it.packet_emergency   = req_packet_emergency;
            it.packet_end_travel  = req_packet_end_travel;
            it.button_up          = req_button_up;
            it.button_down        = req_button_down;
            it.motor_feedback     = req_motor_feedback;
            it.emergency_feedback = req_emergency_feedback;
            it.speed1_feedback    = req_speed1_feedback;
            it.speed2_feedback    = req_speed2_feedback;
            it.brake_switch       = req_brake_switch;
            due_results.push_back(advance_tick(it));
         end

         pending <= due_results.size();
      end
   end

endmodule

### test/hoist_remote_interlock_controller_tb.sv
module hoist_remote_interlock_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hric_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int LONG_HOLD   = 200;
   localparam int SETTLE      = 20;
   localparam int QUIET_TICKS = 60;

   // commands outside the enum, ignored by the block
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;

   typedef enum int {SEG_RUN, SEG_SILENT, SEG_LOCAL, SEG_NOISE} seg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid              = 1'b0;
   logic       req_stall;
   logic       req_packet_valid       = 1'b0;
   logic [2:0] req_packet_command     = CMD_NONE;
   logic       req_packet_hold        = 1'b0;
   logic       req_packet_emergency   = 1'b0;
   logic       req_packet_end_travel  = 1'b0;
   logic       req_button_up          = 1'b0;
   logic       req_button_down        = 1'b0;
   logic       req_motor_feedback     = 1'b0;
   logic       req_emergency_feedback = 1'b0;
   logic       req_speed1_feedback    = 1'b0;
   logic       req_speed2_feedback    = 1'b0;
   logic       req_brake_switch       = 1'b0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_drive_up;
   logic                   rsp_drive_down;
   logic                   rsp_speed1_pulse;
   logic                   rsp_speed2_pulse;
   logic                   rsp_reset_pulse;
   logic                   rsp_emergency_out;
   logic                   rsp_end_travel_out;
   logic                   rsp_status_send;
   logic [STATUS_BITS-1:0] rsp_status_word;
   logic                   rsp_link_led;

   logic                     psel    = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr   = '0;
   logic [CSR_DATA_BITS-1:0] pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   int failures;
   int pending;

   bit quiet         = 1'b0;
   bit long_hold_req = 1'b0;
   logic [CFG_BITS-1:0] link_cfg = LINK_TIMEOUT_RESET;

   // slowly changing controller feedback
   logic fb_motor = 1'b1, fb_emg = 1'b0, fb_s1 = 1'b0, fb_s2 = 1'b0, fb_brake = 1'b0;

   hoist_remote_interlock_controller uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_packet_valid       (req_packet_valid),
      .req_packet_command     (req_packet_command),
      .req_packet_hold        (req_packet_hold),
      .req_packet_emergency   (req_packet_emergency),
      .req_packet_end_travel  (req_packet_end_travel),
      .req_button_up          (req_button_up),
      .req_button_down        (req_button_down),
      .req_motor_feedback     (req_motor_feedback),
      .req_emergency_feedback (req_emergency_feedback),
      .req_speed1_feedback    (req_speed1_feedback),
      .req_speed2_feedback    (req_speed2_feedback),
      .req_brake_switch       (req_brake_switch),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_drive_up           (rsp_drive_up),
      .rsp_drive_down         (rsp_drive_down),
      .rsp_speed1_pulse       (rsp_speed1_pulse),
      .rsp_speed2_pulse       (rsp_speed2_pulse),
      .rsp_reset_pulse        (rsp_reset_pulse),
      .rsp_emergency_out      (rsp_emergency_out),
      .rsp_end_travel_out     (rsp_end_travel_out),
      .rsp_status_send        (rsp_status_send),
      .rsp_status_word        (rsp_status_word),
      .rsp_link_led           (rsp_link_led),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready)
   );

   hric_checker watch (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_packet_valid       (req_packet_valid),
      .req_packet_command     (req_packet_command),
      .req_packet_hold        (req_packet_hold),
      .req_packet_emergency   (req_packet_emergency),
      .req_packet_end_travel  (req_packet_end_travel),
      .req_button_up          (req_button_up),
      .req_button_down        (req_button_down),
      .req_motor_feedback     (req_motor_feedback),
      .req_emergency_feedback (req_emergency_feedback),
      .req_speed1_feedback    (req_speed1_feedback),
      .req_speed2_feedback    (req_speed2_feedback),
      .req_brake_switch       (req_brake_switch),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_drive_up           (rsp_drive_up),
      .rsp_drive_down         (rsp_drive_down),
      .rsp_speed1_pulse       (rsp_speed1_pulse),
      .rsp_speed2_pulse       (rsp_speed2_pulse),
      .rsp_reset_pulse        (rsp_reset_pulse),
      .rsp_emergency_out      (rsp_emergency_out),
      .rsp_end_travel_out     (rsp_end_travel_out),
      .rsp_status_send        (rsp_status_send),
      .rsp_status_word        (rsp_status_word),
      .rsp_link_led           (rsp_link_led),
      .psel                   (psel),
      .penable                (penable),
      .pwrite                 (pwrite),
      .paddr                  (paddr),
      .pwdata                 (pwdata),
      .prdata                 (prdata),
      .pready                 (pready),
      .failures               (failures),
      .pending                (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic item_type mk(input bit pv, input logic [2:0] cmd, input bit hold,
                                   input bit emg, input bit endt, input bit bup,
                                   input bit bdn, input bit mot, input bit femg,
                                   input bit s1, input bit s2, input bit brk);
      item_type it;
      it.packet_valid       = pv;
      it.packet_command     = cmd;
      it.packet_hold        = hold;
      it.packet_emergency   = emg;
      it.packet_end_travel  = endt;
      it.button_up          = bup;
      it.button_down        = bdn;
      it.motor_feedback     = mot;
      it.emergency_feedback = femg;
      it.speed1_feedback    = s1;
      it.speed2_feedback    = s2;
      it.brake_switch       = brk;
      return it;
   endfunction

   function automatic item_type rand_tick(input seg_type k);
      item_type it;
      logic [31:0] raw;
      if ($urandom_range(0, 19) == 0) begin
         fb_motor = ($urandom_range(0, 4) != 0);
         fb_emg   = ($urandom_range(0, 5) == 0);
         fb_s1    = 1'($urandom_range(0, 1));
         fb_s2    = 1'($urandom_range(0, 1));
         fb_brake = ($urandom_range(0, 5) == 0);
      end
      it = mk(0, CMD_NONE, 0, 0, 0, 0, 0, fb_motor, fb_emg, fb_s1, fb_s2, fb_brake);
      case (k)
         SEG_RUN: begin
            it.packet_valid = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 9))
               0, 1, 2: it.packet_command = CMD_UP;
               3, 4, 5: it.packet_command = CMD_DOWN;
               6:       it.packet_command = CMD_SPEED1;
               7:       it.packet_command = CMD_SPEED2;
               8:       it.packet_command = CMD_RST;
               default: it.packet_command = 3'($urandom_range(0, 7));
            endcase
            it.packet_hold       = ($urandom_range(0, 4) != 0);
            it.packet_emergency  = ($urandom_range(0, 9) == 0);
            it.packet_end_travel = 1'($urandom_range(0, 1));
         end
         SEG_LOCAL: begin
            it.packet_valid   = ($urandom_range(0, 7) == 0);
            it.packet_command = 3'($urandom_range(0, 7));
            it.packet_hold    = 1'($urandom_range(0, 1));
            it.button_up      = 1'($urandom_range(0, 1));
            it.button_down    = 1'($urandom_range(0, 1));
         end
         SEG_NOISE: begin
            raw = $urandom;
            it  = raw[$bits(item_type)-1:0];
         end
         default: ;
      endcase
      return it;
   endfunction

   // offer one beat, hold it until taken, then maybe leave a gap
   task automatic offer_tick(input item_type it);
      req_valid              <= 1'b1;
      req_packet_valid       <= it.packet_valid;
      req_packet_command     <= it.packet_command;
      req_packet_hold        <= it.packet_hold;
      req_packet_emergency   <= it.packet_emergency;
      req_packet_end_travel  <= it.packet_end_travel;
      req_button_up          <= it.button_up;
      req_button_down        <= it.button_down;
      req_motor_feedback     <= it.motor_feedback;
      req_emergency_feedback <= it.emergency_feedback;
      req_speed1_feedback    <= it.speed1_feedback;
      req_speed2_feedback    <= it.speed2_feedback;
      req_brake_switch       <= it.brake_switch;
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CFG_BITS-1:0] val);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = $urandom;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {junk[CSR_DATA_BITS-1:CFG_BITS], val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (idx == REG_LINK_TIMEOUT) link_cfg = val;
   endtask

   task automatic csr_read(input reg_index_type idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_BITS-1:0] link, input logic [CFG_BITS-1:0] pulse,
                            input logic [CFG_BITS-1:0] beat, input logic [CFG_BITS-1:0] blink);
      drain();
      csr_write(REG_LINK_TIMEOUT, link);
      csr_write(REG_PULSE_LENGTH, pulse);
      csr_write(REG_STATUS_INTERVAL, beat);
      csr_write(REG_BLINK_HALF, blink);
      csr_read(REG_LINK_TIMEOUT);
      csr_read(REG_PULSE_LENGTH);
      csr_read(REG_STATUS_INTERVAL);
      csr_read(REG_BLINK_HALF);
   endtask

   task automatic run_random(input int count);
      int left, len, cap;
      seg_type k;
      left = count;
      while (left > 0) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: k = SEG_RUN;
            10, 11, 12, 13:               k = SEG_SILENT;
            14, 15, 16:                   k = SEG_LOCAL;
            default:                      k = SEG_NOISE;
         endcase
         len = $urandom_range(3, 30);
         if (k == SEG_SILENT) begin
            // long enough to lose the link now and then
            cap = (link_cfg > 60) ? 60 : int'(link_cfg) + 8;
            len = $urandom_range(1, cap);
         end
         for (int i = 0; i < len && left > 0; i++) begin
            offer_tick(rand_tick(k));
            left--;
         end
      end
   endtask

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel || reset)
            stuck = 0;
         else
            stuck++;
      end
      $display("hoist_remote_interlock_controller_tb NOT OK");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: short timers so loss, blink and pulse ends show up quickly
      configure(16'd4, 16'd3, 16'd5, 16'd2);
      offer_tick(mk(0, CMD_NONE,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      offer_tick(mk(1, CMD_SPARE7, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
      offer_tick(mk(1, CMD_SPARE6, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      offer_tick(mk(1, CMD_NONE,   1, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      offer_tick(mk(1, CMD_UP,     1, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      offer_tick(mk(0, CMD_NONE,   0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      offer_tick(mk(0, CMD_NONE,   0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
      offer_tick(mk(1, CMD_DOWN,   1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      offer_tick(mk(1, CMD_DOWN,   1, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      offer_tick(mk(0, CMD_NONE,   0, 0, 0, 0, 0, 1, 1, 0, 0, 0));
      offer_tick(mk(1, CMD_DOWN,   0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      offer_tick(mk(0, CMD_NONE,   0, 0, 0, 1, 0, 1, 0, 0, 0, 0));
      offer_tick(mk(0, CMD_NONE,   0, 0, 0, 0, 1, 1, 0, 0, 0, 0));
      offer_tick(mk(0, CMD_NONE,   0, 0, 0, 1, 1, 1, 0, 0, 0, 0));
      // hold with a speed command drops the hold
      offer_tick(mk(1, CMD_SPEED1, 1, 0, 0, 0, 0, 1, 0, 1, 0, 0));
      offer_tick(mk(1, CMD_SPEED2, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0));
      offer_tick(mk(1, CMD_SPEED1, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0));
      offer_tick(mk(1, CMD_RST,    0, 1, 1, 0, 0, 1, 0, 0, 0, 0));
      offer_tick(mk(1, CMD_NONE,   0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      repeat (7) offer_tick(mk(0, CMD_NONE, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0));
      offer_tick(mk(1, CMD_UP,     1, 0, 0, 0, 0, 1, 0, 0, 0, 0));

      // all registers zero: always lost, no pulse, send and toggle every tick
      configure(16'd0, 16'd0, 16'd0, 16'd0);
      offer_tick(mk(1, CMD_SPEED1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      offer_tick(mk(1, CMD_UP,     1, 1, 1, 1, 0, 1, 0, 0, 0, 0));
      repeat (8) offer_tick(rand_tick(SEG_NOISE));

      // largest registers: nothing expires over a quiet stretch
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      quiet = 1'b1;
      offer_tick(mk(1, CMD_SPEED1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      repeat (QUIET_TICKS) offer_tick(mk(0, CMD_NONE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      quiet = 1'b0;

      configure(16'd1, 16'd1, 16'd1, 16'd1);
      run_random(250);

      configure(CFG_BITS'($urandom_range(2, 30)), CFG_BITS'($urandom_range(2, 30)),
                CFG_BITS'($urandom_range(2, 30)), CFG_BITS'($urandom_range(2, 30)));
      run_random(150);
      long_hold_req = 1'b1;
      run_random(100);
      drain();
      run_random(150);

      configure(16'd12, 16'hFFFF, 16'hFFFF, 16'd1);
      run_random(250);

      configure(CFG_BITS'($urandom_range(2, 40)), CFG_BITS'($urandom_range(2, 40)),
                CFG_BITS'($urandom_range(2, 40)), CFG_BITS'($urandom_range(2, 40)));
      run_random(350);
      quiet = 1'b1;
      run_random(150);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (failures == 0)
         $display("hoist_remote_interlock_controller_tb OK");
      else
         $display("hoist_remote_interlock_controller_tb NOT OK");
      $finish;
   end

endmodule

### sim.f
rtl/core/hric_pkg.sv
rtl/core/hric_core.sv
rtl/core/hoist_remote_interlock_controller.sv
test/hric_checker.sv
test/hoist_remote_interlock_controller_tb.sv
